/* design/spd_pkg.sv */
// Shared types and constants for the serial packet deframer.
`timescale 1ns / 1ps
package spd_pkg;

  localparam int unsigned LenLimit  = 4095;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [7:0] LineFeed   = 8'h0A;
  localparam logic [7:0] StripMask  = 8'h7F;
  localparam logic [8:0] IdleSatMax = 9'h1FF;

  typedef enum logic [2:0] {
    REG_START_CHAR   = 3'd0,
    REG_END_CHAR     = 3'd1,
    REG_PARITY_ON    = 3'd2,
    REG_MAX_LEN      = 3'd3,
    REG_TIMEOUT_SECS = 3'd4
  } spd_reg_e;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_TIMEOUT = 2'd3
  } spd_kind_e;

  // Classification of one accepted word, settled by the front end.
  typedef enum logic [1:0] {
    CLS_TICK  = 2'd0,
    CLS_START = 2'd1,
    CLS_TERM  = 2'd2,
    CLS_OTHER = 2'd3
  } spd_class_e;

  typedef enum logic {
    ST_HUNT   = 1'b0,
    ST_PACKET = 1'b1
  } spd_state_e;

  typedef struct packed {
    logic [7:0]  start_char;
    logic [7:0]  end_char;
    logic        parity_on;
    logic [11:0] max_len;
    logic [7:0]  timeout_secs;
  } spd_cfg_t;

  typedef struct packed {
    spd_class_e cls;
    logic [7:0] raw;
  } spd_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } spd_qstat_t;

endpackage

/* design/serial_packet_deframer.sv */
// Top level of the serial packet deframer: configuration registers and the front/back split.
// Each accepted word is written into the queue; its result is registered in the back end's result stage when it leaves.
// Throughput: one word per cycle while the result channel takes each result, set by the state update in the back end.
// The two-entry queue lets the front keep accepting while a result waits at the output.
// Reset: registers return to their defaults, the block hunts for a start character,
// the queue empties and no result is pending; no clearing pass is needed.
`timescale 1ns / 1ps
module serial_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [11:0] byte_index_o,
  output logic [11:0] packet_length_o
);
  import spd_pkg::*;

  spd_cfg_t   cfg_q, cfg_d;
  spd_item_t  push_item;
  spd_item_t  head;
  spd_qstat_t qstat;
  logic       push;
  logic       pop;

  // Take a register write; unknown indexes drop silently, data is masked to width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_CHAR:   cfg_d.start_char   = cfg_data_i[7:0];
        REG_END_CHAR:     cfg_d.end_char     = cfg_data_i[7:0];
        REG_PARITY_ON:    cfg_d.parity_on    = cfg_data_i[0];
        REG_MAX_LEN:      cfg_d.max_len      = cfg_data_i;
        REG_TIMEOUT_SECS: cfg_d.timeout_secs = cfg_data_i[7:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char   <= 8'd1;
      cfg_q.end_char     <= 8'd13;
      cfg_q.parity_on    <= 1'b0;
      cfg_q.max_len      <= 12'd94;
      cfg_q.timeout_secs <= 8'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: classify each word as it is accepted and push it into the queue.
  spd_front u_front (
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Hold classified words until the back end can take them.
  spd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // Back end: advance the packet state and register at most one result per word.
  spd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .head_i          (head),
    .qstat_i         (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .packet_length_o (packet_length_o)
  );

endmodule

/* design/spd_front.sv */
// Front end: accepts input words and classifies them against the configured characters.
`timescale 1ns / 1ps
module spd_front (
  input  spd_pkg::spd_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [7:0]         rx_byte_i,
  input  spd_pkg::spd_qstat_t qstat_i,
  output logic               push_o,
  output spd_pkg::spd_item_t push_item_o
);
  import spd_pkg::*;

  logic [7:0] cmp_char;

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign cmp_char   = cfg_i.parity_on ? (rx_byte_i & StripMask) : rx_byte_i;

  always_comb begin
    push_item_o.raw = rx_byte_i;
    // Start test wins over the terminator test.
    priority if (operation_i) begin
      push_item_o.cls = CLS_TICK;
    end else if (cmp_char == cfg_i.start_char) begin
      push_item_o.cls = CLS_START;
    end else if (cmp_char == cfg_i.end_char || cmp_char == LineFeed) begin
      push_item_o.cls = CLS_TERM;
    end else begin
      push_item_o.cls = CLS_OTHER;
    end
  end

endmodule

/* design/spd_queue.sv */
// Short queue of classified words between the front and back ends.
`timescale 1ns / 1ps
module spd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  spd_pkg::spd_item_t  push_item_i,
  input  logic                pop_i,
  output spd_pkg::spd_item_t  head_o,
  output spd_pkg::spd_qstat_t qstat_o
);
  import spd_pkg::*;

  spd_item_t        mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(FifoDepth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign qstat_o.empty = (count_q == '0);
  assign qstat_o.full  = (count_q == CntW'(FifoDepth));
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* design/spd_back.sv */
// Back end: packet state, idle timer and the registered result stage.
`timescale 1ns / 1ps
module spd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spd_pkg::spd_cfg_t   cfg_i,
  input  spd_pkg::spd_item_t  head_i,
  input  spd_pkg::spd_qstat_t qstat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          data_byte_o,
  output logic [11:0]         byte_index_o,
  output logic [11:0]         packet_length_o
);
  import spd_pkg::*;

  localparam logic [11:0] LenLimitW = 12'(LenLimit);

  spd_state_e  state_q, state_d;
  logic [11:0] count_q, count_d;
  logic [8:0]  idle_q, idle_d;
  logic        out_valid_q, out_valid_d;
  spd_kind_e   kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [11:0] index_q, index_d;
  logic [11:0] length_q, length_d;

  logic        has_res;
  logic [8:0]  idle_inc;
  logic        timed_out;
  logic [11:0] limit;
  logic        at_limit;

  assign pop_o     = !qstat_i.empty && (!out_valid_q || out_ready_i);
  assign idle_inc  = (idle_q == IdleSatMax) ? idle_q : idle_q + 9'd1;
  assign timed_out = idle_inc > {1'b0, cfg_i.timeout_secs};
  assign limit     = (LenLimitW < cfg_i.max_len) ? LenLimitW : cfg_i.max_len;
  assign at_limit  = count_q >= limit;

  // Next state.
  always_comb begin
    state_d = state_q;
    if (pop_o) begin
      unique case (head_i.cls)
        CLS_TICK:  if (timed_out) state_d = ST_HUNT;
        CLS_START: state_d = ST_PACKET;
        CLS_TERM:  state_d = ST_HUNT;
        CLS_OTHER: if (at_limit) state_d = ST_HUNT;
        default:   state_d = state_q;
      endcase
    end
  end

  // Counters and result.
  always_comb begin
    count_d  = count_q;
    idle_d   = idle_q;
    has_res  = 1'b0;
    kind_d   = kind_q;
    data_d   = '0;
    index_d  = '0;
    length_d = '0;
    if (pop_o) begin
      idle_d = '0;
      unique case (head_i.cls)
        CLS_TICK: begin
          if (timed_out) begin
            count_d = '0;
            has_res = 1'b1;
            kind_d  = KIND_TIMEOUT;
          end else begin
            idle_d = idle_inc;
          end
        end
        CLS_START: ;
        CLS_TERM: begin
          if (state_q == ST_PACKET) begin
            count_d  = '0;
            has_res  = 1'b1;
            kind_d   = KIND_DONE;
            length_d = count_q;
          end
        end
        CLS_OTHER: begin
          if (state_q == ST_PACKET) begin
            has_res = 1'b1;
            if (at_limit) begin
              count_d = '0;
              kind_d  = KIND_LONG;
            end else begin
              kind_d  = KIND_DATA;
              data_d  = head_i.raw;
              index_d = count_q;
              count_d = count_q + 12'd1;
            end
          end
        end
        default: ;
      endcase
    end
    out_valid_d = pop_o ? has_res : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      count_q     <= '0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      kind_q   <= kind_d;
      data_q   <= data_d;
      index_q  <= index_d;
      length_q <= length_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = data_q;
  assign byte_index_o    = index_q;
  assign packet_length_o = length_q;

endmodule
